// ===== rtl/core/wpr_pkg.sv =====
// Shared widths, constants, register indexes and bundle types for the
// windowed PI pressure regulator. No dependencies.
package wpr_pkg;

	localparam int MEAS_W    = 40;  // pressure, 2^-40 torr per LSB
	localparam int ERR_W     = 41;  // signed pressure error
	localparam int GAIN_W    = 10;  // integer gains
	localparam int P_W       = 51;  // signed Kp * error
	localparam int SP_W      = 46;  // setpoint, 0..50 in 2^-40 units
	localparam int ADJ_OUT_W = 47;  // reported adjustment, saturated to +-50
	localparam int M100_W    = 47;  // |error| * 100

	// 0.01 and 50.0 in 2^-40 units
	localparam longint THRESH = 64'sd10995116278;
	localparam longint SP_MAX = 64'sd54975581388800;

	// Configuration port
	localparam int APB_DW = 64;
	localparam int APB_AW = 5;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] REG_TARGET = 2'd0;
	localparam logic [IDX_W-1:0] REG_KP     = 2'd1;
	localparam logic [IDX_W-1:0] REG_KI     = 2'd2;

	localparam logic [MEAS_W-1:0] TARGET_RST = 40'd1099511628;
	localparam logic [GAIN_W-1:0] KP_RST     = 10'd600;
	localparam logic [GAIN_W-1:0] KI_RST     = 10'd500;

	typedef struct packed {
		logic [MEAS_W-1:0] target;
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
	} wpr_cfg_t;

	typedef struct packed {
		logic signed [ERR_W-1:0] err;
		logic signed [P_W-1:0]   p;
		logic                    deadband;  // |err|*100 < target
		logic                    small_p;   // |P| < 0.01
	} wpr_front_t;

	typedef struct packed {
		logic commit;   // item leaves the input register this cycle
		logic active;   // valid sample outside the deadband
		logic small_p;  // proportional term small enough for integral mode
	} wpr_step_t;

endpackage

// ===== rtl/core/wpr_in_if.sv =====
// Request channel carrying one pressure sample.
// Depends on wpr_pkg for field widths.
interface wpr_in_if import wpr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MEAS_W-1:0] sensed_pressure;
	logic              sample_ok;

	modport source(output valid, sensed_pressure, sample_ok, input ready);
	modport sink(input valid, sensed_pressure, sample_ok, output ready);
endinterface

// ===== rtl/core/wpr_out_if.sv =====
// Result channel carrying the new setpoint, adjustment and mode flag.
// Depends on wpr_pkg for field widths.
interface wpr_out_if import wpr_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [SP_W-1:0]             flow_setpoint;
	logic signed [ADJ_OUT_W-1:0] applied_adjustment;
	logic                        integral_engaged;

	modport source(output valid, flow_setpoint, applied_adjustment, integral_engaged,
		input ready);
	modport sink(input valid, flow_setpoint, applied_adjustment, integral_engaged,
		output ready);
endinterface

// ===== rtl/core/wpr_cfg_regs.sv =====
// APB-style configuration registers: target pressure and the two gains.
// Depends on wpr_pkg.
module wpr_cfg_regs import wpr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output wpr_cfg_t          cfg
);

	wpr_cfg_t         cfg_q;
	logic             wr_en;
	logic [IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[APB_AW-1:APB_AW-IDX_W];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target <= TARGET_RST;
			cfg_q.kp     <= KP_RST;
			cfg_q.ki     <= KI_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_TARGET: cfg_q.target <= pwdata[MEAS_W-1:0];
				REG_KP:     cfg_q.kp     <= pwdata[GAIN_W-1:0];
				REG_KI:     cfg_q.ki     <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TARGET: prdata = APB_DW'(cfg_q.target);
			REG_KP:     prdata = APB_DW'(cfg_q.kp);
			REG_KI:     prdata = APB_DW'(cfg_q.ki);
			default:    prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/wpr_error_front.sv =====
// Error, deadband test and proportional term for one sample.
// Depends on wpr_pkg.
module wpr_error_front import wpr_pkg::*; (
	input  logic [MEAS_W-1:0] meas,
	input  wpr_cfg_t          cfg,
	output wpr_front_t        front
);

	logic signed [ERR_W-1:0] err;
	logic signed [ERR_W-1:0] neg_err;
	logic [MEAS_W-1:0]       abs_err;
	logic [M100_W-1:0]       err_x100;
	logic signed [P_W-1:0]   p;

	assign err     = $signed({1'b0, cfg.target}) - $signed({1'b0, meas});
	assign neg_err = -err;
	assign abs_err = err[ERR_W-1] ? neg_err[MEAS_W-1:0] : err[MEAS_W-1:0];

	// 100 = 64 + 32 + 4
	assign err_x100 = (M100_W'(abs_err) << 6) + (M100_W'(abs_err) << 5)
		+ (M100_W'(abs_err) << 2);

	assign p = $signed({1'b0, cfg.kp}) * err;

	assign front.err      = err;
	assign front.p        = p;
	assign front.deadband = err_x100 < M100_W'(cfg.target);
	assign front.small_p  = (p < P_W'(THRESH)) && (p > -P_W'(THRESH));

endmodule

// ===== rtl/core/wpr_error_window.sv =====
// Moving window of recent errors with running sum, fill count and mode flag.
// Depends on wpr_pkg.
module wpr_error_window import wpr_pkg::*; #(
	parameter int WINDOW_LEN = 10,
	parameter int SUM_W      = ERR_W + $clog2(WINDOW_LEN)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  wpr_step_t               step,
	input  logic signed [ERR_W-1:0] err,
	output logic signed [SUM_W-1:0] new_sum,
	output logic                    full,
	output logic                    mode
);

	localparam int POS_W  = $clog2(WINDOW_LEN);
	localparam int FILL_W = $clog2(WINDOW_LEN + 1);

	logic signed [ERR_W-1:0] ring_q [WINDOW_LEN];
	logic [WINDOW_LEN-1:0]   valid_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [FILL_W-1:0]       fill_q;
	logic [FILL_W-1:0]       fill_new;
	logic [POS_W-1:0]        pos_q;
	logic                    mode_q;
	logic signed [ERR_W-1:0] old_err;
	logic                    push;
	logic                    leave;

	// The window is kept clear whenever integral mode is off, so entering
	// the mode needs no extra clear.
	assign push  = step.commit && step.active && step.small_p;
	assign leave = step.commit && step.active && !step.small_p && mode_q;

	assign old_err  = valid_q[pos_q] ? ring_q[pos_q] : '0;
	assign new_sum  = sum_q - SUM_W'(old_err) + SUM_W'(err);
	assign fill_new = (fill_q == FILL_W'(WINDOW_LEN)) ? fill_q : fill_q + 1'b1;
	assign full     = fill_new == FILL_W'(WINDOW_LEN);
	assign mode     = mode_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ring_q[pos_q] <= err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			sum_q   <= '0;
			fill_q  <= '0;
			pos_q   <= '0;
			mode_q  <= 1'b0;
		end else if (push) begin
			valid_q[pos_q] <= 1'b1;
			sum_q          <= new_sum;
			fill_q         <= fill_new;
			pos_q          <= (pos_q == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_q + 1'b1;
			mode_q         <= 1'b1;
		end else if (leave) begin
			valid_q <= '0;
			sum_q   <= '0;
			fill_q  <= '0;
			mode_q  <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/wpr_setpoint.sv =====
// Integral term, adjustment deadzone, setpoint register and clamping.
// Depends on wpr_pkg.
module wpr_setpoint import wpr_pkg::*; #(
	parameter int SUM_W = 45
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wpr_step_t                   step,
	input  logic signed [P_W-1:0]       p,
	input  logic signed [SUM_W-1:0]     window_sum,
	input  logic                        use_integ,
	input  logic [GAIN_W-1:0]           ki,
	output logic [SP_W-1:0]             setpoint,
	output logic signed [ADJ_OUT_W-1:0] adjustment
);

	localparam int INT_W = SUM_W + GAIN_W;
	localparam int ADJ_W = ((INT_W > P_W) ? INT_W : P_W) + 1;
	localparam int NS_W  = ADJ_W + 1;

	logic [SP_W-1:0]         sp_q;
	logic [SP_W-1:0]         sp_next;
	logic signed [INT_W-1:0] integ;
	logic signed [ADJ_W-1:0] adj_raw;
	logic signed [ADJ_W-1:0] adj;
	logic signed [NS_W-1:0]  ns;
	logic signed [ADJ_OUT_W-1:0] adj_sat;

	assign integ   = $signed({1'b0, ki}) * window_sum;
	assign adj_raw = ADJ_W'(p) + (use_integ ? ADJ_W'(integ) : '0);
	// drop adjustments below 0.01
	assign adj = ((adj_raw < ADJ_W'(THRESH)) && (adj_raw > -ADJ_W'(THRESH)))
		? '0 : adj_raw;
	assign ns  = $signed(NS_W'({1'b0, sp_q})) + NS_W'(adj);

	always_comb begin
		if (ns < 0) begin
			sp_next = '0;
		end else if (ns > NS_W'(SP_MAX)) begin
			sp_next = SP_W'(SP_MAX);
		end else begin
			sp_next = ns[SP_W-1:0];
		end
		if (adj > ADJ_W'(SP_MAX)) begin
			adj_sat = ADJ_OUT_W'(SP_MAX);
		end else if (adj < -ADJ_W'(SP_MAX)) begin
			adj_sat = -ADJ_OUT_W'(SP_MAX);
		end else begin
			adj_sat = adj[ADJ_OUT_W-1:0];
		end
	end

	assign setpoint   = step.active ? sp_next : sp_q;
	assign adjustment = step.active ? adj_sat : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (step.commit && step.active) begin
			sp_q <= sp_next;
		end
	end

endmodule

// ===== rtl/core/windowed_pi_pressure_regulator.sv =====
// Top level of the windowed PI pressure regulator.
// Depends on wpr_pkg, wpr_in_if, wpr_out_if and the wpr_* submodules.
//
// Usage:
//   sample  - request channel, one measured pressure per request plus a
//             sensor-ok flag. A request is taken when valid and ready are high.
//   result  - one result per request: new flow setpoint (0..50, 2^-40 units),
//             the adjustment applied, and whether integral mode is engaged.
//   APB     - target pressure at 0x00, Kp at 0x08, Ki at 0x10 (64-bit data).
//             Write only while no request is in flight.
// Timing:
//   A request sits in the input register while the error, P term, window update,
//   I term and clamp are evaluated combinationally; the result is registered as
//   the request leaves that register. One request per cycle is sustained while
//   results are taken; the path is set by the Kp and Ki multipliers.
// Reset:
//   arst_n clears setpoint, window, mode and channel registers; restores defaults.
// Stall:
//   With the result held, the next request still enters the empty input
//   register; further requests wait until the result is taken.
module windowed_pi_pressure_regulator import wpr_pkg::*; #(
	parameter int WINDOW_LEN = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	wpr_in_if.sink            sample,
	wpr_out_if.source         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int SUM_W = ERR_W + $clog2(WINDOW_LEN);

	// input register
	logic              valid_s1;
	logic [MEAS_W-1:0] meas_s1;
	logic              ok_s1;

	// result register
	logic                        out_valid_q;
	logic [SP_W-1:0]             flow_q;
	logic signed [ADJ_OUT_W-1:0] adj_q;
	logic                        eng_q;

	wpr_cfg_t                cfg;
	wpr_front_t              front;
	wpr_step_t               step;
	logic                    advance;
	logic signed [SUM_W-1:0] new_sum;
	logic                    win_full;
	logic                    mode;
	logic [SP_W-1:0]         sp_res;
	logic signed [ADJ_OUT_W-1:0] adj_res;
	logic                    eng_res;

	wpr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance the input register whenever the result register is free or
	// being drained this cycle.
	assign advance      = !out_valid_q || result.ready;
	assign sample.ready = !valid_s1 || advance;

	assign step.commit  = valid_s1 && advance;
	assign step.active  = ok_s1 && !front.deadband;
	assign step.small_p = front.small_p;

	wpr_error_front u_front (
		.meas  (meas_s1),
		.cfg   (cfg),
		.front (front)
	);

	wpr_error_window #(
		.WINDOW_LEN (WINDOW_LEN),
		.SUM_W      (SUM_W)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.err     (front.err),
		.new_sum (new_sum),
		.full    (win_full),
		.mode    (mode)
	);

	wpr_setpoint #(
		.SUM_W (SUM_W)
	) u_setpoint (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.p          (front.p),
		.window_sum (new_sum),
		.use_integ  (front.small_p && win_full),
		.ki         (cfg.ki),
		.setpoint   (sp_res),
		.adjustment (adj_res)
	);

	// Skipped samples report the mode unchanged.
	assign eng_res = step.active ? front.small_p : mode;

	// Hold payload; no reset needed.
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			meas_s1 <= sample.sensed_pressure;
			ok_s1   <= sample.sample_ok;
		end
		if (step.commit) begin
			flow_q <= sp_res;
			adj_q  <= adj_res;
			eng_q  <= eng_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (sample.valid && sample.ready) begin
				valid_s1 <= 1'b1;
			end else if (step.commit) begin
				valid_s1 <= 1'b0;
			end
			if (step.commit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid              = out_valid_q;
	assign result.flow_setpoint      = flow_q;
	assign result.applied_adjustment = adj_q;
	assign result.integral_engaged   = eng_q;

`ifndef SYNTHESIS
	a_commit_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step.commit |=> out_valid_q)
		else $error("request left input stage without producing a result");

	a_setpoint_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (flow_q <= SP_W'(SP_MAX)))
		else $error("flow setpoint above upper clamp");

	a_skip_no_adjust: assert property (@(posedge clk) disable iff (!arst_n)
		(step.commit && !step.active) |=> (adj_q == '0))
		else $error("nonzero adjustment on skipped sample");

	a_skip_keeps_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(step.commit && !step.active) |=> (eng_q == $past(mode)))
		else $error("skipped sample changed integral mode");
`endif

endmodule

// ===== sim/tb_windowed_pi_pressure_regulator.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the windowed PI pressure regulator: directed table, then
// randomized register settings and sample bursts, checked against an in-bench regulator model.
// Depends on wpr_pkg, wpr_in_if, wpr_out_if and windowed_pi_pressure_regulator.
module tb_windowed_pi_pressure_regulator;
	import wpr_pkg::*;

	localparam int     WINDOW          = 10;
	localparam int     PERIOD_NS       = 12;
	localparam int     RESET_CYCLES    = 12;
	localparam int     CYCLE_LIMIT     = 800000;
	localparam int     PHASE_SAMPLES   = 225;
	localparam int     HOLD_OFF_CYCLES = 300;
	localparam int     TAIL_CYCLES     = 10;
	localparam longint MEAS_TOP        = 64'sd1099511627775;

	localparam logic [MEAS_W-1:0] MEAS_MAX = '1;

	// One result as it leaves the block
	typedef struct packed {
		logic [SP_W-1:0]             flow_setpoint;
		logic signed [ADJ_OUT_W-1:0] applied_adjustment;
		logic                        integral_engaged;
	} regulation_t;

	typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_e;

	// Directed table row; a config row carries the target in the pressure field
	typedef struct {
		row_kind_e         kind;
		logic [MEAS_W-1:0] pressure;
		logic              sample_ok;
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		bit                typed;
		regulation_t       want;
	} directed_row_t;

	// One random phase: register setting plus how hard to push the handshakes
	typedef struct {
		logic [MEAS_W-1:0] target;
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		bit                quiet;
		bit                hold_off;
		bit                mid_drain;
	} setting_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	wpr_in_if  sample_bus();
	wpr_out_if result_bus();

	windowed_pi_pressure_regulator #(
		.WINDOW_LEN(WINDOW)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_bus),
		.result(result_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #(PERIOD_NS / 2) clk = ~clk;

	// Regulator model state: register copies, setpoint and error window
	logic [MEAS_W-1:0] cfg_target;
	logic [GAIN_W-1:0] cfg_kp;
	logic [GAIN_W-1:0] cfg_ki;
	longint            sp_now;
	longint            err_window [WINDOW];
	int                window_slot;
	int                window_fill;
	longint            window_total;
	bit                integral_on;

	// Results still owed by the block, oldest first
	regulation_t pending_results[$];

	int errors = 0;
	int samples_sent = 0;
	int live_samples = 0;
	int results_seen = 0;
	int integral_results = 0;
	int saturated_results = 0;
	int settings_used = 0;
	int input_stall_cycles = 0;
	int cycle_count = 0;
	bit quiet = 1'b0;
	int hold_off_request = 0;

	function automatic longint magnitude(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic void clear_window();
		foreach (err_window[i])
			err_window[i] = 0;
		window_total = 0;
		window_fill  = 0;
	endfunction

	// Advance the regulator model by one accepted request and return the result it owes.
	// The ring slot keeps wrapping across mode changes; only contents, sum and fill clear.
	function automatic regulation_t regulate_sample(logic [MEAS_W-1:0] meas, logic ok);
		longint      tgt;
		longint      err;
		longint      p;
		longint      integ;
		longint      adj;
		longint      ns;
		regulation_t r;
		tgt = longint'({24'd0, cfg_target});
		err = tgt - longint'({24'd0, meas});
		adj = 0;
		// skip invalid samples and errors inside the 1 percent deadband
		if (ok && magnitude(err) * 100 >= tgt) begin
			p     = longint'({54'd0, cfg_kp}) * err;
			integ = 0;
			if (magnitude(p) < THRESH) begin
				if (!integral_on) begin
					integral_on = 1'b1;
					clear_window();
				end
				window_total = window_total - err_window[window_slot] + err;
				err_window[window_slot] = err;
				window_slot = (window_slot + 1) % WINDOW;
				if (window_fill < WINDOW)
					window_fill++;
				if (window_fill >= WINDOW)
					integ = longint'({54'd0, cfg_ki}) * window_total;
			end else if (integral_on) begin
				integral_on = 1'b0;
				clear_window();
			end
			adj = p + integ;
			if (magnitude(adj) < THRESH)
				adj = 0;
			// the setpoint takes the full adjustment; only the reported value saturates
			ns = sp_now + adj;
			if (ns < 0)
				ns = 0;
			if (ns > SP_MAX)
				ns = SP_MAX;
			sp_now = ns;
			if (adj > SP_MAX)
				adj = SP_MAX;
			else if (adj < -SP_MAX)
				adj = -SP_MAX;
		end
		r.flow_setpoint      = sp_now[SP_W-1:0];
		r.applied_adjustment = adj[ADJ_OUT_W-1:0];
		r.integral_engaged   = integral_on;
		return r;
	endfunction

	function automatic logic [MEAS_W-1:0] any_pressure();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[MEAS_W-1:0];
	endfunction

	// Pick a pressure whose error magnitude lies in lo..hi, either sign, kept in range
	function automatic logic [MEAS_W-1:0] pressure_off_target(longint lo, longint hi);
		longint      tgt;
		longint      mag;
		longint      meas;
		logic [63:0] r;
		tgt = longint'({24'd0, cfg_target});
		if (lo > hi)
			return any_pressure();
		r    = {$urandom, $urandom};
		mag  = lo + longint'(r % (hi - lo + 1));
		meas = $urandom_range(0, 1) ? tgt - mag : tgt + mag;
		if (meas < 0)
			meas = tgt + mag;
		if (meas > MEAS_TOP)
			meas = tgt - mag;
		if (meas < 0)
			return any_pressure();
		return meas[MEAS_W-1:0];
	endfunction

	// Error just outside the deadband with a small P term: drives integral mode
	function automatic logic [MEAS_W-1:0] band_pressure();
		longint tgt;
		longint kp;
		tgt = longint'({24'd0, cfg_target});
		kp  = longint'({54'd0, cfg_kp});
		return pressure_off_target((tgt + 99) / 100, kp == 0 ? MEAS_TOP : (THRESH - 1) / kp);
	endfunction

	function automatic logic [MEAS_W-1:0] deadband_pressure();
		longint tgt;
		tgt = longint'({24'd0, cfg_target});
		if (tgt == 0)
			return any_pressure();
		return pressure_off_target(0, (tgt - 1) / 100);
	endfunction

	// Mostly back-to-back, sometimes a short gap, rarely a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 70)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic directed_row_t sample_row(logic [MEAS_W-1:0] meas, logic ok);
		directed_row_t r;
		r.kind      = ROW_SAMPLE;
		r.pressure  = meas;
		r.sample_ok = ok;
		r.kp        = '0;
		r.ki        = '0;
		r.typed     = 1'b0;
		r.want      = '0;
		return r;
	endfunction

	function automatic directed_row_t known_row(logic [MEAS_W-1:0] meas, logic ok,
		longint sp, longint adj, logic mode);
		directed_row_t r;
		r = sample_row(meas, ok);
		r.typed                   = 1'b1;
		r.want.flow_setpoint      = sp[SP_W-1:0];
		r.want.applied_adjustment = adj[ADJ_OUT_W-1:0];
		r.want.integral_engaged   = mode;
		return r;
	endfunction

	function automatic directed_row_t settings_row(logic [MEAS_W-1:0] target,
		logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki);
		directed_row_t r;
		r = sample_row(target, 1'b0);
		r.kind = ROW_CONFIG;
		r.kp   = kp;
		r.ki   = ki;
		return r;
	endfunction

	// Offer one request after a random gap and hold it until taken. Valid stays high
	// afterwards so a following request can go back-to-back.
	task automatic send_sample(logic [MEAS_W-1:0] meas, logic ok, bit typed, regulation_t want);
		int          gap;
		regulation_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			sample_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_bus.valid           <= 1'b1;
		sample_bus.sensed_pressure <= meas;
		sample_bus.sample_ok       <= ok;
		do @(posedge clk); while (!sample_bus.ready);
		predicted = regulate_sample(meas, ok);
		pending_results.push_back(typed ? want : predicted);
		samples_sent++;
		if (ok)
			live_samples++;
	endtask

	task automatic end_burst();
		sample_bus.valid <= 1'b0;
	endtask

	// Always wait on the clock before testing, so valid has dropped before anything else happens
	task automatic wait_drain();
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Write all three registers back-to-back; psel stays high between them
	task automatic write_settings(logic [MEAS_W-1:0] target, logic [GAIN_W-1:0] kp,
		logic [GAIN_W-1:0] ki);
		logic [IDX_W-1:0]  reg_index [3];
		logic [APB_DW-1:0] reg_data [3];
		reg_index = '{REG_TARGET, REG_KP, REG_KI};
		reg_data  = '{APB_DW'(target), APB_DW'(kp), APB_DW'(ki)};
		for (int i = 0; i < 3; i++) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= {reg_index[i], 3'b000};
			pwdata  <= reg_data[i];
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_target = target;
		cfg_kp     = kp;
		cfg_ki     = ki;
		settings_used++;
	endtask

	// Cycle budget and input back-pressure count
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (sample_bus.valid && !sample_bus.ready)
			input_stall_cycles <= input_stall_cycles + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** windowed_pi_pressure_regulator: FAILED **");
			$finish;
		end
	end

	// Result side: check every taken result against the oldest expectation, then pick
	// the next ready. A hold-off request from the stimulus is counted down here.
	initial begin
		int          stall_left;
		regulation_t got;
		regulation_t want;
		stall_left = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_bus.valid && result_bus.ready) begin
				got.flow_setpoint      = result_bus.flow_setpoint;
				got.applied_adjustment = result_bus.applied_adjustment;
				got.integral_engaged   = result_bus.integral_engaged;
				results_seen++;
				if (pending_results.size() == 0) begin
					$error("result with no request outstanding: setpoint %0d, adjustment %0d",
						got.flow_setpoint, got.applied_adjustment);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (got.flow_setpoint !== want.flow_setpoint) begin
						$error("flow_setpoint: expected %0d, actual %0d",
							want.flow_setpoint, got.flow_setpoint);
						errors++;
					end
					if (got.applied_adjustment !== want.applied_adjustment) begin
						$error("applied_adjustment: expected %0d, actual %0d",
							want.applied_adjustment, got.applied_adjustment);
						errors++;
					end
					if (got.integral_engaged !== want.integral_engaged) begin
						$error("integral_engaged: expected %0d, actual %0d",
							want.integral_engaged, got.integral_engaged);
						errors++;
					end
					if (want.integral_engaged)
						integral_results++;
					if (magnitude(longint'(want.applied_adjustment)) == SP_MAX)
						saturated_results++;
				end
			end
			if (hold_off_request > 0) begin
				stall_left       = hold_off_request;
				hold_off_request = 0;
			end
			if (stall_left > 0) begin
				result_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				result_bus.ready <= 1'b1;
				if (!quiet && $urandom_range(0, 99) < 20)
					stall_left = pick_gap();
			end
		end
	end

	// Stimulus: reset, directed table, then one random phase per register setting
	initial begin
		directed_row_t     rows[$];
		setting_t          plan [8];
		regulation_t       none;
		int                phase_start;
		int                burst;
		int                pick;
		bit                drained;
		logic [MEAS_W-1:0] meas;
		logic [63:0]       wide;

		none = '0;
		arst_n                     <= 1'b0;
		psel                       <= 1'b0;
		penable                    <= 1'b0;
		pwrite                     <= 1'b0;
		paddr                      <= '0;
		pwdata                     <= '0;
		sample_bus.valid           <= 1'b0;
		sample_bus.sensed_pressure <= '0;
		sample_bus.sample_ok       <= 1'b0;

		// model starts from the reset registers and an empty window
		cfg_target  = TARGET_RST;
		cfg_kp      = KP_RST;
		cfg_ki      = KI_RST;
		sp_now      = 0;
		clear_window();
		window_slot = 0;
		integral_on = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, from reset registers (target about 0.001, Kp 600, Ki 500).
		// Invalid samples leave everything at reset.
		rows.push_back(known_row(MEAS_MAX, 1'b0, 0, 0, 1'b0));
		rows.push_back(known_row('0, 1'b0, 0, 0, 1'b0));
		// zero error sits in the deadband
		rows.push_back(known_row(TARGET_RST, 1'b1, 0, 0, 1'b0));
		// full-scale pressure: setpoint clamps at zero, reported adjustment saturates
		rows.push_back(known_row(MEAS_MAX, 1'b1, 0, -SP_MAX, 1'b0));
		// zero pressure: adjustment is Kp times the target
		rows.push_back(known_row('0, 1'b1, 64'sd659706976800, 64'sd659706976800, 1'b0));
		// small P enters integral mode; adjustment below 0.01 drops to zero
		rows.push_back(known_row(TARGET_RST - 40'd15000000, 1'b1, 64'sd659706976800, 0, 1'b1));
		// fill the window so the I term kicks in
		for (int k = 1; k <= 8; k++)
			rows.push_back(sample_row(TARGET_RST - 40'd15000000 - 40'(k * 100000), 1'b1));
		rows.push_back(sample_row(TARGET_RST + 40'd15000000, 1'b1));
		// deadband and invalid sample while integral mode is engaged
		rows.push_back(sample_row(TARGET_RST - 40'd1000, 1'b1));
		rows.push_back(sample_row(TARGET_RST + 40'd17000000, 1'b0));
		// large error drops out of integral mode
		rows.push_back(sample_row('0, 1'b1));
		// top target and gains: setpoint clamps at 50; zero error is in the deadband
		rows.push_back(settings_row(MEAS_MAX, 10'd1023, 10'd1023));
		rows.push_back(known_row('0, 1'b1, SP_MAX, SP_MAX, 1'b0));
		rows.push_back(known_row(MEAS_MAX, 1'b1, SP_MAX, 0, 1'b0));
		// zero target never hits the deadband; zero Kp keeps integral mode on
		rows.push_back(settings_row('0, '0, '0));
		rows.push_back(known_row('0, 1'b1, SP_MAX, 0, 1'b1));
		rows.push_back(sample_row(MEAS_MAX, 1'b1));

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CONFIG) begin
				end_burst();
				wait_drain();
				write_settings(rows[i].pressure, rows[i].kp, rows[i].ki);
			end else begin
				send_sample(rows[i].pressure, rows[i].sample_ok, rows[i].typed, rows[i].want);
			end
		end
		end_burst();
		wait_drain();

		// Random phases: settings from reset values to both extremes and random picks
		wide = {$urandom, $urandom};
		plan[0] = '{TARGET_RST, KP_RST, KI_RST, 1'b0, 1'b0, 1'b1};
		plan[1] = '{'0, '0, 10'd1023, 1'b0, 1'b0, 1'b0};
		plan[2] = '{MEAS_MAX, 10'd1023, '0, 1'b0, 1'b0, 1'b1};
		plan[3] = '{40'($urandom_range(1, 1 << 30)), 10'($urandom_range(1, 1023)),
			10'($urandom), 1'b0, 1'b0, 1'b0};
		plan[4] = '{40'd1, 10'd1, 10'd1, 1'b1, 1'b1, 1'b0};
		plan[5] = '{wide[MEAS_W-1:0], 10'($urandom), 10'($urandom), 1'b0, 1'b0, 1'b0};
		plan[6] = '{TARGET_RST, '0, 10'd1023, 1'b0, 1'b0, 1'b1};
		plan[7] = '{40'd1048576, 10'd1023, 10'd1023, 1'b0, 1'b0, 1'b0};

		foreach (plan[ph]) begin
			write_settings(plan[ph].target, plan[ph].kp, plan[ph].ki);
			quiet = plan[ph].quiet;
			// hold off the result side while requests keep coming, so the block backs up
			if (plan[ph].hold_off)
				hold_off_request = HOLD_OFF_CYCLES;
			drained     = 1'b0;
			phase_start = live_samples;
			while (live_samples - phase_start < PHASE_SAMPLES) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					// integral-band run, often long enough to fill the window, now and then broken
					burst = $urandom_range(8, 24);
					repeat (burst) begin
						meas = ($urandom_range(0, 9) == 0) ? any_pressure() : band_pressure();
						send_sample(meas, 1'b1, 1'b0, none);
					end
				end else if (pick < 70) begin
					burst = $urandom_range(1, 4);
					repeat (burst)
						send_sample(deadband_pressure(), 1'b1, 1'b0, none);
				end else if (pick < 85) begin
					burst = $urandom_range(1, 4);
					repeat (burst)
						send_sample(any_pressure(), $urandom_range(0, 3) != 0, 1'b0, none);
				end else if (pick < 95) begin
					burst = $urandom_range(1, 3);
					repeat (burst)
						send_sample(any_pressure(), 1'b0, 1'b0, none);
				end else begin
					meas = $urandom_range(0, 1) ? MEAS_MAX : '0;
					send_sample(meas, 1'b1, 1'b0, none);
				end
				// pause the sender once mid-phase until every result is back
				if (plan[ph].mid_drain && !drained &&
					live_samples - phase_start >= PHASE_SAMPLES / 2) begin
					end_burst();
					wait_drain();
					drained = 1'b1;
				end
			end
			end_burst();
			wait_drain();
		end

		quiet = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d samples (%0d regulated) over %0d register settings, %0d results",
			samples_sent, live_samples, settings_used, results_seen);
		$display("%0d in integral mode, %0d saturated, %0d input stall cycles, %0d mismatches",
			integral_results, saturated_results, input_stall_cycles, errors);
		if (errors == 0)
			$display("** windowed_pi_pressure_regulator: PASSED **");
		else
			$display("** windowed_pi_pressure_regulator: FAILED **");
		$finish;
	end

endmodule

// ===== windowed_pi_pressure_regulator.f =====
rtl/core/wpr_pkg.sv
rtl/core/wpr_in_if.sv
rtl/core/wpr_out_if.sv
rtl/core/wpr_cfg_regs.sv
rtl/core/wpr_error_front.sv
rtl/core/wpr_error_window.sv
rtl/core/wpr_setpoint.sv
rtl/core/windowed_pi_pressure_regulator.sv
sim/tb_windowed_pi_pressure_regulator.sv
